// ===== design/msh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_pkg
// Shared types and constants for the multi-algorithm string hash.
// ----------------------------------------------------------------------------
package msh_pkg;

    localparam int HASH_W = 32;

    // algorithm select codes
    localparam logic [3:0] ALG_RS    = 4'd0;
    localparam logic [3:0] ALG_JS    = 4'd1;
    localparam logic [3:0] ALG_PJW   = 4'd2;
    localparam logic [3:0] ALG_ELF   = 4'd3;
    localparam logic [3:0] ALG_BKDR  = 4'd4;
    localparam logic [3:0] ALG_SDBM  = 4'd5;
    localparam logic [3:0] ALG_DJB   = 4'd6;
    localparam logic [3:0] ALG_DEK   = 4'd7;
    localparam logic [3:0] ALG_BP    = 4'd8;
    localparam logic [3:0] ALG_FNV   = 4'd9;
    localparam logic [3:0] ALG_AP    = 4'd10;
    localparam logic [3:0] ALG_SHXOR = 4'd11;

    // configuration register indexes
    localparam logic CFG_ALGORITHM = 1'b0;
    localparam logic CFG_SEED      = 1'b1;

    localparam logic [31:0] RS_B_CONST      = 32'd378551;
    localparam logic [31:0] RS_A_INIT       = 32'd63689;
    localparam logic [31:0] JS_INIT         = 32'd1315423911;
    localparam logic [31:0] BKDR_SEED_RESET = 32'd131;
    localparam logic [31:0] DJB_INIT        = 32'd5381;
    localparam logic [31:0] FNV_MULT        = 32'h811C_9DC5;
    localparam logic [31:0] AP_INIT         = 32'hAAAA_AAAA;

    typedef struct packed {
        logic [31:0] string_length;
        logic        empty_string;
        logic        last_byte;
        logic        first_byte;
        logic [7:0]  data_byte;
    } msh_item_t;

    typedef struct packed {
        logic [31:0] running_hash;
        logic [31:0] rs_multiplier;
        logic        byte_parity;
    } msh_state_t;

endpackage

// ===== design/msh_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_step
// One-byte update of the running hash for all algorithms, with string start
// and empty-string handling. One shared multiplier serves RS, BKDR, FNV, AP.
// ----------------------------------------------------------------------------
module msh_step (
    input  msh_pkg::msh_item_t  item,
    input  logic [3:0]          hash_algorithm,
    input  logic [31:0]         multiplier_seed,
    input  msh_pkg::msh_state_t state_cur,
    output msh_pkg::msh_state_t state_next,
    output logic [31:0]         hash_out,
    output logic                emits
);
    import msh_pkg::*;

    logic [31:0] init_hash;
    logic [31:0] h;
    logic [31:0] rsm;
    logic        parity;
    logic [31:0] c;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] prod;
    logic [31:0] shl4;
    logic [31:0] shx;
    logic [31:0] h_new;

    always_comb
    begin
        unique case (hash_algorithm)
            ALG_JS:  init_hash = JS_INIT;
            ALG_DJB: init_hash = DJB_INIT;
            ALG_DEK: init_hash = item.string_length;
            ALG_AP:  init_hash = AP_INIT;
            default: init_hash = '0;
        endcase
    end

    // a start of string reloads the state before the byte is applied
    assign h      = item.first_byte ? init_hash : state_cur.running_hash;
    assign rsm    = item.first_byte ? RS_A_INIT : state_cur.rs_multiplier;
    assign parity = item.first_byte ? 1'b0 : state_cur.byte_parity;
    assign c      = {24'd0, item.data_byte};

    always_comb
    begin
        unique case (hash_algorithm)
            ALG_RS:
            begin
                mul_a = h;
                mul_b = rsm;
            end
            ALG_BKDR:
            begin
                mul_a = h;
                mul_b = multiplier_seed;
            end
            ALG_FNV:
            begin
                mul_a = h;
                mul_b = FNV_MULT;
            end
            ALG_AP:
            begin
                mul_a = {3'd0, h[31:3]};
                mul_b = c;
            end
            default:
            begin
                mul_a = h;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;   // low word only

    // PJW and ELF agree: fold top nibble into bits 7:4, then clear it
    assign shl4 = {h[27:0], 4'd0} + c;
    assign shx  = h ^ {28'd0, h[31:28]};

    always_comb
    begin
        unique case (hash_algorithm)
            ALG_RS:    h_new = prod + c;
            ALG_JS:    h_new = h ^ ({h[26:0], 5'd0} + c + {2'd0, h[31:2]});
            ALG_PJW,
            ALG_ELF:   h_new = {4'd0, shl4[27:8], shl4[7:4] ^ shl4[31:28], shl4[3:0]};
            ALG_BKDR:  h_new = prod + c;
            ALG_SDBM:  h_new = c + {h[25:0], 6'd0} + {h[15:0], 16'd0} - h;
            ALG_DJB:   h_new = {h[26:0], 5'd0} + h + c;
            ALG_DEK:   h_new = {h[26:0], 5'd0} ^ {27'd0, h[31:27]} ^ c;
            ALG_BP:    h_new = {h[24:0], 7'd0} ^ c;
            ALG_FNV:   h_new = prod ^ c;
            ALG_AP:
            begin
                if (!parity)
                    h_new = h ^ ({h[24:0], 7'd0} ^ prod);
                else
                    h_new = h ^ ~(({h[20:0], 11'd0} + c) ^ {5'd0, h[31:5]});
            end
            ALG_SHXOR: h_new = {shx[27:0], 4'd0} ^ c;
            default:   h_new = h;
        endcase
    end

    always_comb
    begin
        if (item.empty_string)
        begin
            state_next.running_hash  = init_hash;
            state_next.rs_multiplier = RS_A_INIT;
            state_next.byte_parity   = 1'b0;
            hash_out                 = init_hash;
        end
        else
        begin
            state_next.running_hash  = h_new;
            state_next.rs_multiplier = rsm * RS_B_CONST;
            state_next.byte_parity   = ~parity;
            hash_out                 = h_new;
        end
    end

    assign emits = item.empty_string | item.last_byte;

endmodule

// ===== design/multi_algorithm_string_hash.sv =====
`timescale 1ns / 1ps
// Datapath: input register, combinational hash step, 2-entry result buffer.
// Throughput: one byte per cycle while the result buffer has room or the byte
// ends no string; the hash step sits between the input register and buffer.
// Reset (rst_n low, async): state to RS defaults, algorithm 0, seed 131,
// no beats in flight.
// ----------------------------------------------------------------------------
// multi_algorithm_string_hash
// Byte-streamed 32-bit string hash with twelve selectable algorithms.
// ----------------------------------------------------------------------------
module multi_algorithm_string_hash (
    input  logic        clk,
    input  logic        rst_n,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] string_length
    input  logic [1:0]  s_tuser,   // [0] first_byte, [1] empty_string
    input  logic        s_tlast,   // last_byte
    // hash output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash_value
);
    import msh_pkg::*;

    logic [3:0]  hash_algorithm_reg;
    logic [31:0] multiplier_seed_reg;

    msh_item_t   in_item;
    msh_item_t   in_data_reg;
    logic        in_valid_reg;

    msh_state_t  state_reg;
    msh_state_t  state_next;
    logic [31:0] hash_out;
    logic        emits;

    logic [31:0] fifo_mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        fifo_room;
    logic        advance;
    logic        push;
    logic        pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_algorithm_reg  <= ALG_RS;
            multiplier_seed_reg <= BKDR_SEED_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ALGORITHM: hash_algorithm_reg  <= cfg_data[3:0];
                CFG_SEED:      multiplier_seed_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign in_item.data_byte     = s_tdata[7:0];
    assign in_item.string_length = s_tdata[39:8];
    assign in_item.first_byte    = s_tuser[0];
    assign in_item.empty_string  = s_tuser[1];
    assign in_item.last_byte     = s_tlast;

    assign fifo_room = (count_reg != 2'd2);
    assign advance   = in_valid_reg && (fifo_room || !emits);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= in_item;
    end

    msh_step u_step (
        .item            (in_data_reg),
        .hash_algorithm  (hash_algorithm_reg),
        .multiplier_seed (multiplier_seed_reg),
        .state_cur       (state_reg),
        .state_next      (state_next),
        .hash_out        (hash_out),
        .emits           (emits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.running_hash  <= '0;
            state_reg.rs_multiplier <= RS_A_INIT;
            state_reg.byte_parity   <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // two-entry result buffer decouples m_tready from s_tready
    assign push = advance && emits;
    assign pop  = m_tvalid && m_tready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem_reg[wr_ptr_reg] <= hash_out;
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = fifo_mem_reg[rd_ptr_reg];

endmodule

// ===== tb/multi_algorithm_string_hash_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_algorithm_string_hash_tb
// Streams strings byte by byte through the hash block under every algorithm
// code and several multiplier seeds. A behavioral copy of the hash state runs
// alongside and queues the hash due for each string end; a checker pops and
// compares each result beat. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module multi_algorithm_string_hash_tb;

    import msh_pkg::*;

    localparam int          CLK_PERIOD     = 8;
    localparam int          ITEM_TARGET    = 1550;
    localparam int          DRAIN_CYCLES   = 6;
    localparam int          MAX_REPORTS    = 10;
    localparam int          IDLE_PERCENT   = 19;
    localparam logic [3:0]  ALG_UNUSED_TOP = 4'hF;
    localparam logic [31:0] TOP_NIBBLE     = 32'hF000_0000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [7:0] data_byte, [39:8] string_length
    logic [1:0]  s_tuser;   // [0] first_byte, [1] empty_string
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // [31:0] hash_value

    // shadow of the block's registers and hash state
    logic [3:0]  cur_alg;
    logic [31:0] cur_seed;
    logic [31:0] acc_hash;
    logic [31:0] rs_mult;
    logic        ap_odd;

    logic [31:0] hash_due[$];
    int          items_sent;
    int          mismatches;
    bit          calm;

    multi_algorithm_string_hash dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [31:0] start_value(input logic [31:0] len);
        case (cur_alg)
            ALG_JS:  return JS_INIT;
            ALG_DJB: return DJB_INIT;
            ALG_DEK: return len;
            ALG_AP:  return AP_INIT;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] c);
        logic [31:0] cw;
        logic [31:0] t;
        logic [31:0] hi;
        logic [31:0] m;
        cw = {24'd0, c};
        case (cur_alg)
            ALG_RS:   return h * rs_mult + cw;
            ALG_JS:   return h ^ ((h << 5) + cw + (h >> 2));
            ALG_PJW:
            begin
                t  = (h << 4) + cw;
                hi = t & TOP_NIBBLE;
                if (hi != 0)
                    t = (t ^ (hi >> 24)) & ~TOP_NIBBLE;
                return t;
            end
            ALG_ELF:
            begin
                t  = (h << 4) + cw;
                hi = t & TOP_NIBBLE;
                if (hi != 0)
                    t = t ^ (hi >> 24);
                return t & ~hi;
            end
            ALG_BKDR: return h * cur_seed + cw;
            ALG_SDBM: return cw + (h << 6) + (h << 16) - h;
            ALG_DJB:  return (h << 5) + h + cw;
            ALG_DEK:  return ((h << 5) ^ (h >> 27)) ^ cw;
            ALG_BP:   return (h << 7) ^ cw;
            ALG_FNV:  return (h * FNV_MULT) ^ cw;
            ALG_AP:
            begin
                m = cw * (h >> 3);
                if (!ap_odd)
                    return h ^ ((h << 7) ^ m);
                return h ^ ~(((h << 11) + cw) ^ (h >> 5));
            end
            ALG_SHXOR:
            begin
                t = (h ^ (h >> 28)) << 4;
                return t ^ cw;
            end
            default:  return h;
        endcase
    endfunction

    task automatic predict_byte(input logic [7:0] data, input logic first, input logic last,
                                input logic empty, input logic [31:0] len);
        if (empty || first)
        begin
            acc_hash = start_value(len);
            rs_mult  = RS_A_INIT;
            ap_odd   = 1'b0;
        end
        if (empty)
        begin
            hash_due.push_back(acc_hash);
        end
        else
        begin
            acc_hash = hash_step(acc_hash, data);
            rs_mult  = rs_mult * RS_B_CONST;
            ap_odd   = ~ap_odd;
            if (last)
                hash_due.push_back(acc_hash);
        end
    endtask

    // one input beat; valid stays high when the next beat follows directly
    task automatic send_byte(input logic [7:0] data, input logic first, input logic last,
                             input logic empty, input logic [31:0] len);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, data};
        s_tuser  <= {empty, first};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_byte(data, first, last, empty, len);
        items_sent++;
    endtask

    // stop the byte stream and let every pending hash come out
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (hash_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_ALGORITHM)
            cur_alg = val[3:0];
        else
            cur_seed = val;
        @(posedge clk);
    endtask

    // result checker and output back-pressure
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (hash_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected hash beat: got %08h", m_tdata);
            end
            else if (m_tdata !== hash_due[0])
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("hash mismatch: expected %08h got %08h", hash_due[0], m_tdata);
                void'(hash_due.pop_front());
            end
            else
            begin
                void'(hash_due.pop_front());
            end
        end
    end

    // bytes with no start mark continue from the reset state
    task automatic test_bytes_after_reset;
        send_byte(8'h00, 1'b0, 1'b0, 1'b0, 32'd0);
        send_byte(8'hFF, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_empty_strings;
        write_reg(CFG_ALGORITHM, {28'd0, ALG_DEK});
        send_byte(8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        drain();
        write_reg(CFG_ALGORITHM, {28'd0, ALG_AP});
        send_byte(8'h00, 1'b0, 1'b0, 1'b1, 32'd0);
        drain();
    endtask

    // one-byte string per algorithm; bkdr runs on the reset seed
    task automatic test_each_algorithm;
        for (int code = ALG_RS; code <= ALG_SHXOR; code++)
        begin
            write_reg(CFG_ALGORITHM, code);
            send_byte(code[0] ? 8'hFF : 8'h80, 1'b1, 1'b1, 1'b0,
                      code[0] ? 32'hFFFF_FFFF : 32'd0);
            drain();
        end
    endtask

    task automatic test_mid_string_switch;
        write_reg(CFG_ALGORITHM, {28'd0, ALG_FNV});
        send_byte(8'hA5, 1'b1, 1'b0, 1'b0, 32'd3);
        drain();
        write_reg(CFG_ALGORITHM, {28'd0, ALG_AP});
        send_byte(8'h5A, 1'b0, 1'b0, 1'b0, 32'd3);
        send_byte(8'h3C, 1'b0, 1'b1, 1'b0, 32'd3);
        drain();
    endtask

    // codes above shift-xor hold the hash but still advance multiplier and parity
    task automatic test_unused_codes;
        write_reg(CFG_ALGORITHM, {28'd0, ALG_UNUSED_TOP});
        send_byte(8'h7E, 1'b1, 1'b0, 1'b0, 32'd2);
        send_byte(8'h01, 1'b0, 1'b1, 1'b0, 32'd2);
        drain();
        write_reg(CFG_ALGORITHM, {28'd0, ALG_RS});
        send_byte(8'h11, 1'b0, 1'b1, 1'b0, 32'd0);
        drain();
    endtask

    function automatic logic [7:0] pick_byte;
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // well-formed strings with random content, plus empty, headless,
    // restarted and unterminated strings
    task automatic test_random_strings;
        int          phase;
        int          kind;
        int          count;
        int          n_str;
        logic [3:0]  code;
        logic [31:0] seed;
        logic [31:0] len;
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            calm = (phase >= 10 && phase < 14);
            if ($urandom_range(9) == 0)
                code = 4'($urandom_range(ALG_UNUSED_TOP, ALG_SHXOR + 1));
            else
                code = 4'($urandom_range(ALG_SHXOR, ALG_RS));
            write_reg(CFG_ALGORITHM, {28'd0, code});
            if ($urandom_range(2) == 0 || code == ALG_BKDR)
            begin
                case ($urandom_range(5))
                    0:       seed = 32'd0;
                    1:       seed = 32'hFFFF_FFFF;
                    2:       seed = BKDR_SEED_RESET;
                    default: seed = $urandom;
                endcase
                write_reg(CFG_SEED, seed);
            end
            n_str = $urandom_range(4, 10);
            for (int s = 0; s < n_str; s++)
            begin
                kind  = $urandom_range(99);
                count = ($urandom_range(9) == 0) ? $urandom_range(1, 48)
                                                 : $urandom_range(1, 12);
                len   = ($urandom_range(9) < 7) ? count : $urandom;
                if (kind < 10)
                begin
                    send_byte(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'b1, len);
                end
                else if (kind < 15)
                begin
                    send_byte(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'b0, len);
                end
                else
                begin
                    for (int i = 0; i < count; i++)
                    begin
                        send_byte(pick_byte(),
                                  (kind < 90) ? (i == 0) :
                                  (kind < 95) ? (i == count / 2) : 1'b0,
                                  (kind < 97) ? (i == count - 1) : 1'b0,
                                  1'b0, len);
                    end
                end
            end
            drain();
            phase++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_ALGORITHM;
        cfg_data   = 32'd0;
        s_tvalid   = 1'b0;
        s_tdata    = 40'd0;
        s_tuser    = 2'b00;
        s_tlast    = 1'b0;
        cur_alg    = ALG_RS;
        cur_seed   = BKDR_SEED_RESET;
        acc_hash   = 32'd0;
        rs_mult    = RS_A_INIT;
        ap_odd     = 1'b0;
        items_sent = 0;
        mismatches = 0;
        calm       = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bytes_after_reset();
        test_empty_strings();
        test_each_algorithm();
        test_mid_string_switch();
        test_unused_codes();
        test_random_strings();
        drain();

        if (mismatches == 0 && hash_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
